>>> hdl/qeb_pkg.sv
// Shared types, constants and codes of the quadrature encoder with button unit.
`default_nettype none
package qeb_pkg;

  localparam int NUM_ENCODERS = 8;
  localparam int ENC_W = 3;
  localparam int ADDR_W = 3;
  localparam int TICK_W = 16;
  localparam int HIST_W = 16;
  localparam int CODE_W = 4;
  localparam int REG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [HIST_W-1:0] PATTERN_CW = 16'he817;
  localparam logic [HIST_W-1:0] PATTERN_CCW = 16'hd42b;
  localparam logic [TICK_W-1:0] TICK_MAX = 16'hffff;
  // Bit c is set when transition code c is a legal quadrature step.
  localparam logic [15:0] CODE_OK = 16'h6996;

  localparam logic [TICK_W-1:0] DEAD_TICKS_RESET = 16'd2;
  localparam logic [TICK_W-1:0] LONG_PRESS_TICKS_RESET = 16'd100;

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_LONG     = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_PRESSED  = 3'd0,
    KIND_LONG     = 3'd1,
    KIND_RELEASED = 3'd2,
    KIND_CLICKED  = 3'd3,
    KIND_ROTATED  = 3'd4
  } kind_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PRESSED_LEVEL    = 2'd0,
    REG_BUTTON_ENABLE    = 2'd1,
    REG_DEAD_TICKS       = 2'd2,
    REG_LONG_PRESS_TICKS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CODE_W-1:0] phase_code;
    logic [HIST_W-1:0] history;
    mode_t             mode;
    logic [TICK_W-1:0] press_ticks;
  } enc_state_t;

  typedef struct packed {
    logic              pressed_level;
    logic [7:0]        button_enable;
    logic [TICK_W-1:0] dead_ticks;
    logic [TICK_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic signed [1:0] step;
  } evt_t;

  typedef struct packed {
    logic [ENC_W-1:0] enc;
    logic [1:0]       count;
    evt_t [2:0]       evts;
  } bundle_t;

endpackage
`default_nettype wire

>>> hdl/qeb_if.sv
// Channel interfaces for samples, events and register writes.
`default_nettype none
interface qeb_sample_if import qeb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ENC_W-1:0] encoder_index;
  logic             phase_a;
  logic             phase_b;
  logic             button_level;
  modport source (output valid, encoder_index, phase_a, phase_b, button_level, input ready);
  modport sink (input valid, encoder_index, phase_a, phase_b, button_level, output ready);
endinterface

interface qeb_event_if import qeb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ENC_W-1:0]  event_encoder;
  logic [2:0]        event_kind;
  logic signed [1:0] rotation_step;
  logic              last_event;
  modport source (output valid, event_encoder, event_kind, rotation_step, last_event,
                  input ready);
  modport sink (input valid, event_encoder, event_kind, rotation_step, last_event,
                output ready);
endinterface

interface qeb_cfg_if import qeb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/qeb_state_ram.sv
// Per-encoder state memory with written flags and write-to-read forwarding.
`default_nettype none
module qeb_state_ram import qeb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output enc_state_t             rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire enc_state_t        wr_data
);

  enc_state_t mem [NUM_ENCODERS];
  logic [NUM_ENCODERS-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // An entry never written reads as the reset state.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (written[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/qeb_step.sv
// Button mode machine and phase decoder that update one encoder's state.
`default_nettype none
module qeb_step import qeb_pkg::*; (
  input  wire enc_state_t        cur,
  input  wire cfg_t              cfg,
  input  wire logic [ENC_W-1:0]  enc,
  input  wire logic              phase_a,
  input  wire logic              phase_b,
  input  wire logic              button_level,
  output enc_state_t             nxt,
  output bundle_t                bundle
);

  always_comb begin
    logic [TICK_W-1:0] ticks_up;
    logic [CODE_W-1:0] code;
    logic [HIST_W-1:0] hist;
    logic              ev_btn;
    kind_t             btn_kind;
    logic              ev_click;
    logic              ev_rot;
    logic signed [1:0] rot_step;
    logic [1:0]        n;

    ticks_up = (cur.press_ticks == TICK_MAX) ? cur.press_ticks : cur.press_ticks + 1'b1;
    nxt = cur;
    ev_btn = 1'b0;
    btn_kind = KIND_PRESSED;
    ev_click = 1'b0;
    ev_rot = 1'b0;
    rot_step = 2'sd0;

    if (cfg.button_enable[enc]) begin
      if ((cur.mode == MODE_PRESSED) && (cur.press_ticks < cfg.dead_ticks)) begin
        nxt.press_ticks = ticks_up;
      end else if (button_level == cfg.pressed_level) begin
        if (cur.mode == MODE_RELEASED) begin
          nxt.mode = MODE_PRESSED;
          nxt.press_ticks = '0;
          ev_btn = 1'b1;
          btn_kind = KIND_PRESSED;
        end else begin
          nxt.press_ticks = ticks_up;
          if ((cur.mode == MODE_PRESSED) && (ticks_up >= cfg.long_press_ticks)) begin
            nxt.mode = MODE_LONG;
            ev_btn = 1'b1;
            btn_kind = KIND_LONG;
          end
        end
      end else if (cur.mode != MODE_RELEASED) begin
        nxt.mode = MODE_RELEASED;
        ev_btn = 1'b1;
        btn_kind = KIND_RELEASED;
        ev_click = (cur.mode == MODE_PRESSED);
      end
    end

    code = {cur.phase_code[1:0], phase_b, phase_a};
    hist = {cur.history[HIST_W-CODE_W-1:0], code};
    nxt.phase_code = code;
    if (CODE_OK[code]) begin
      nxt.history = hist;
      if (hist == PATTERN_CW) begin
        ev_rot = 1'b1;
        rot_step = 2'sd1;
      end else if (hist == PATTERN_CCW) begin
        ev_rot = 1'b1;
        rot_step = -2'sd1;
      end
    end

    bundle = '0;
    bundle.enc = enc;
    n = 2'd0;
    if (ev_btn) begin
      bundle.evts[0].kind = btn_kind;
      bundle.evts[0].step = 2'sd0;
      n = 2'd1;
    end
    if (ev_click) begin
      bundle.evts[1].kind = KIND_CLICKED;
      bundle.evts[1].step = 2'sd0;
      n = 2'd2;
    end
    if (ev_rot) begin
      bundle.evts[n].kind = KIND_ROTATED;
      bundle.evts[n].step = rot_step;
      n = n + 2'd1;
    end
    bundle.count = n;
  end

endmodule
`default_nettype wire

>>> hdl/qeb_event_queue.sv
// Queue of per-sample event groups, delivered one event per transaction.
`default_nettype none
module qeb_event_queue import qeb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  input  wire logic    pending,
  output logic         can_accept,
  qeb_event_if.source  result
);

  bundle_t q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [1:0]        sub;
  bundle_t           head;
  logic              last;
  logic              take;
  logic              pop;

  assign head = q[rd_ptr];
  assign last = (sub == (head.count - 2'd1));
  assign take = result.valid && result.ready;
  assign pop = take && last;

  assign result.valid = (count != '0);
  assign result.event_encoder = head.enc;
  assign result.event_kind = head.evts[sub].kind;
  assign result.rotation_step = head.evts[sub].step;
  assign result.last_event = last;

  // Room is kept for the sample still being decoded.
  assign can_accept = ((count + QCNT_W'(pending)) < QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      sub <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
        sub <= '0;
      end else if (take) begin
        sub <= sub + 2'd1;
      end
      unique case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/quadrature_encoder_with_button_unit.sv
// Top level of the quadrature encoder with button unit.
// Each sample transaction carries one tick for one of eight encoders. The
// sample reads that encoder's state from a registered memory, the next cycle
// computes the button and rotation events and writes the state back, with
// forwarding when consecutive samples hit the same encoder. A sample is taken
// every cycle; its zero to three events appear one per result transaction
// through a four-entry event queue, and sample ready drops when the queued
// event groups plus the sample being decoded would fill that queue. Register
// writes are accepted at any time and apply to samples accepted at the same
// clock edge or later.
`default_nettype none
module quadrature_encoder_with_button_unit import qeb_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  qeb_sample_if.sink  sample,
  qeb_event_if.source result,
  qeb_cfg_if.sink     cfg
);

  cfg_t             cfg_regs;
  logic             accept;
  logic             in_range;
  logic             can_accept;
  logic             s1_valid;
  logic [ENC_W-1:0] s1_enc;
  logic             s1_a;
  logic             s1_b;
  logic             s1_lvl;
  enc_state_t       cur;
  enc_state_t       nxt;
  bundle_t          bundle;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pressed_level <= 1'b1;
      cfg_regs.button_enable <= '0;
      cfg_regs.dead_ticks <= DEAD_TICKS_RESET;
      cfg_regs.long_press_ticks <= LONG_PRESS_TICKS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_PRESSED_LEVEL: cfg_regs.pressed_level <= cfg.data[0];
        REG_BUTTON_ENABLE: cfg_regs.button_enable <= cfg.data[7:0];
        REG_DEAD_TICKS: cfg_regs.dead_ticks <= cfg.data;
        REG_LONG_PRESS_TICKS: cfg_regs.long_press_ticks <= cfg.data;
        default: cfg_regs <= cfg_regs;
      endcase
    end
  end

  assign sample.ready = can_accept;
  assign accept = sample.valid && sample.ready;
  assign in_range = (int'(sample.encoder_index) < NUM_ENCODERS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_enc <= sample.encoder_index;
      s1_a <= sample.phase_a;
      s1_b <= sample.phase_b;
      s1_lvl <= sample.button_level;
    end
  end

  qeb_state_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_range),
    .rd_addr (sample.encoder_index[ADDR_W-1:0]),
    .rd_data (cur),
    .wr_en   (s1_valid),
    .wr_addr (s1_enc[ADDR_W-1:0]),
    .wr_data (nxt)
  );

  qeb_step u_step (
    .cur          (cur),
    .cfg          (cfg_regs),
    .enc          (s1_enc),
    .phase_a      (s1_a),
    .phase_b      (s1_b),
    .button_level (s1_lvl),
    .nxt          (nxt),
    .bundle       (bundle)
  );

  qeb_event_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid && (bundle.count != 2'd0)),
    .push_data  (bundle),
    .pending    (s1_valid),
    .can_accept (can_accept),
    .result     (result)
  );

endmodule
`default_nettype wire

>>> hdl/qeb_checker.sv
// Port-level assertions on the event output of the unit, and their binding.
`default_nettype none
module qeb_checker import qeb_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             r_valid,
  input wire logic             r_ready,
  input wire logic [ENC_W-1:0] r_enc,
  input wire logic [2:0]       r_kind,
  input wire logic [1:0]       r_step,
  input wire logic             r_last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_ready) |=> (r_valid && $stable({r_enc, r_kind, r_step, r_last})))
    else $error("stalled result changed");

  a_group_same_encoder: assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_ready && !r_last) |=> (r_valid && (r_enc == $past(r_enc))))
    else $error("event group split across encoders");

  a_rotation_last: assert property (@(posedge clk) disable iff (rst)
    (r_valid && (r_kind == KIND_ROTATED)) |-> (r_last && (r_step != 2'b00)))
    else $error("rotation event not last or without step");

endmodule

bind quadrature_encoder_with_button_unit qeb_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .r_valid (result.valid),
  .r_ready (result.ready),
  .r_enc   (result.event_encoder),
  .r_kind  (result.event_kind),
  .r_step  (result.rotation_step),
  .r_last  (result.last_event)
);
`default_nettype wire

>>> verif/tb_quadrature_encoder_with_button_unit.sv
// Testbench for the quadrature encoder with button unit, checked against a predictor.
`timescale 1ns / 1ps
module tb_quadrature_encoder_with_button_unit;
  import qeb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [15:0] LEGAL_CODES = 16'h6996;
  localparam logic [15:0] CW_HISTORY = 16'he817;
  localparam logic [15:0] CCW_HISTORY = 16'hd42b;
  localparam logic [1:0] GRAY_BA [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

  typedef struct packed {
    logic [ENC_W-1:0] enc;
    logic             a;
    logic             b;
    logic             lvl;
  } tick_t;

  typedef struct packed {
    logic [ENC_W-1:0]  enc;
    kind_t             kind;
    logic signed [1:0] step;
    logic              last;
  } enc_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qeb_sample_if smp();
  qeb_event_if  res();
  qeb_cfg_if    cfg();

  quadrature_encoder_with_button_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg)
  );

  always #6 clk = ~clk;

  logic [3:0]        cur_phase [NUM_ENCODERS];
  logic [15:0]       cur_hist [NUM_ENCODERS];
  mode_t             cur_mode [NUM_ENCODERS];
  logic [TICK_W-1:0] cur_ticks [NUM_ENCODERS];
  logic              pressed_lvl;
  logic [7:0]        btn_enable;
  logic [TICK_W-1:0] dead_limit;
  logic [TICK_W-1:0] long_limit;

  tick_t      pending_ticks [$];
  enc_event_t expected_events [$];
  tick_t      next_tick;
  logic       smp_taken = 1'b0;
  int         issued_cnt = 0;
  int         accepted_cnt = 0;
  int         fail_cnt = 0;
  int         idle_cycles = 0;
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;

  int         gray_pos [NUM_ENCODERS];
  int         spin_dir [NUM_ENCODERS];
  logic [7:0] held_lvl;

  function automatic logic [TICK_W-1:0] tick_up(input logic [TICK_W-1:0] t);
    return (t == TICK_MAX) ? t : t + 1'b1;
  endfunction

  function automatic void decode_tick(input tick_t t);
    enc_event_t evs [$];
    enc_event_t ev;
    logic [3:0] code;
    mode_t      m;
    int         e;
    e = t.enc;
    ev.enc = t.enc;
    ev.kind = KIND_PRESSED;
    ev.step = 2'sb00;
    ev.last = 1'b0;
    if (btn_enable[e]) begin
      m = cur_mode[e];
      if (m == MODE_PRESSED && cur_ticks[e] < dead_limit) begin
        cur_ticks[e] = tick_up(cur_ticks[e]);
      end else if (t.lvl == pressed_lvl) begin
        if (m == MODE_RELEASED) begin
          cur_mode[e] = MODE_PRESSED;
          cur_ticks[e] = '0;
          ev.kind = KIND_PRESSED;
          evs.push_back(ev);
        end else begin
          cur_ticks[e] = tick_up(cur_ticks[e]);
          if (m == MODE_PRESSED && cur_ticks[e] >= long_limit) begin
            cur_mode[e] = MODE_LONG;
            ev.kind = KIND_LONG;
            evs.push_back(ev);
          end
        end
      end else if (m != MODE_RELEASED) begin
        cur_mode[e] = MODE_RELEASED;
        ev.kind = KIND_RELEASED;
        evs.push_back(ev);
        if (m == MODE_PRESSED) begin
          ev.kind = KIND_CLICKED;
          evs.push_back(ev);
        end
      end
    end
    code = {cur_phase[e][1:0], t.b, t.a};
    cur_phase[e] = code;
    if (LEGAL_CODES[code]) begin
      cur_hist[e] = {cur_hist[e][11:0], code};
      if (cur_hist[e] == CW_HISTORY || cur_hist[e] == CCW_HISTORY) begin
        ev.kind = KIND_ROTATED;
        ev.step = (cur_hist[e] == CW_HISTORY) ? 2'sb01 : 2'sb11;
        evs.push_back(ev);
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endfunction

  // Sample driver.
  always @(negedge clk) begin
    if (!smp.valid || smp_taken) begin
      if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        next_tick = pending_ticks.pop_front();
        smp.valid <= 1'b1;
        smp.encoder_index <= next_tick.enc;
        smp.phase_a <= next_tick.a;
        smp.phase_b <= next_tick.b;
        smp.button_level <= next_tick.lvl;
      end else begin
        smp.valid <= 1'b0;
      end
    end
    smp_taken = 1'b0;
  end

  always @(posedge clk) begin
    if (smp.valid && smp.ready) begin
      smp_taken = 1'b1;
      accepted_cnt++;
      decode_tick('{enc: smp.encoder_index, a: smp.phase_a, b: smp.phase_b,
                    lvl: smp.button_level});
    end
  end

  // Event monitor.
  always @(negedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    enc_event_t want;
    if (res.valid && res.ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event transaction: event_encoder %0d event_kind %0d",
               res.event_encoder, res.event_kind);
        fail_cnt++;
      end else begin
        want = expected_events.pop_front();
        if (res.event_encoder !== want.enc) begin
          $error("event_encoder: expected %0d, actual %0d", want.enc, res.event_encoder);
          fail_cnt++;
        end
        if (res.event_kind !== want.kind) begin
          $error("event_kind: expected %0d, actual %0d", want.kind, res.event_kind);
          fail_cnt++;
        end
        if (res.rotation_step !== want.step) begin
          $error("rotation_step: expected %0d, actual %0d", want.step, res.rotation_step);
          fail_cnt++;
        end
        if (res.last_event !== want.last) begin
          $error("last_event: expected %0d, actual %0d", want.last, res.last_event);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_sample(input int e, input logic a, input logic b, input logic lvl);
    pending_ticks.push_back('{enc: e[ENC_W-1:0], a: a, b: b, lvl: lvl});
    issued_cnt++;
  endtask

  task automatic spin_and_queue(input int e, input logic lvl);
    logic [1:0] ba;
    gray_pos[e] = (gray_pos[e] + spin_dir[e]) & 3;
    ba = GRAY_BA[gray_pos[e]];
    queue_sample(e, ba[0], ba[1], lvl);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_cnt != issued_cnt || expected_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk);
    while (!cfg.ready);
    case (idx)
      REG_PRESSED_LEVEL:    pressed_lvl = val[0];
      REG_BUTTON_ENABLE:    btn_enable = val[7:0];
      REG_DEAD_TICKS:       dead_limit = val;
      REG_LONG_PRESS_TICKS: long_limit = val;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_regs(input logic pl, input logic [7:0] en, input logic [15:0] dead_val,
                          input logic [15:0] long_val);
    write_reg(REG_PRESSED_LEVEL, {15'd0, pl});
    write_reg(REG_BUTTON_ENABLE, {8'd0, en});
    write_reg(REG_DEAD_TICKS, dead_val);
    write_reg(REG_LONG_PRESS_TICKS, long_val);
    @(posedge clk);
  endtask

  task automatic add_random_ticks(input int count);
    int e;
    int r;
    logic [1:0] ba;
    for (int i = 0; i < count; i++) begin
      e = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) spin_dir[e] = -spin_dir[e];
      if ($urandom_range(0, 99) < 12) held_lvl[e] = ~held_lvl[e];
      r = $urandom_range(0, 99);
      if (r < 80) begin
        spin_and_queue(e, held_lvl[e]);
      end else begin
        if (r >= 90) gray_pos[e] = $urandom_range(0, 3);
        ba = GRAY_BA[gray_pos[e]];
        queue_sample(e, ba[0], ba[1], ($urandom_range(0, 9) == 0) ? ~held_lvl[e] : held_lvl[e]);
      end
    end
  endtask

  task automatic run_random_phase(input int src_pct, input int snk_pct, input int count);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    add_random_ticks(count / 2);
    wait_idle();
    add_random_ticks(count - count / 2);
    wait_idle();
  endtask

  initial begin
    smp.valid = 1'b0;
    smp.encoder_index = '0;
    smp.phase_a = 1'b0;
    smp.phase_b = 1'b0;
    smp.button_level = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_PRESSED_LEVEL;
    cfg.data = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      cur_phase[i] = '0;
      cur_hist[i] = '0;
      cur_mode[i] = MODE_RELEASED;
      cur_ticks[i] = '0;
      gray_pos[i] = 0;
      spin_dir[i] = 1;
    end
    held_lvl = '0;
    pressed_lvl = 1'b1;
    btn_enable = '0;
    dead_limit = DEAD_TICKS_RESET;
    long_limit = LONG_PRESS_TICKS_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Press with dead time, click, long press, release after long press, and a
    // sample that raises released, clicked and rotated together.
    set_regs(1'b1, 8'h7f, 16'd2, 16'd5);
    queue_sample(0, 1, 0, 1);
    queue_sample(0, 1, 1, 0);
    queue_sample(0, 0, 1, 0);
    queue_sample(0, 0, 0, 0);
    queue_sample(0, 1, 0, 1);
    queue_sample(0, 1, 1, 1);
    queue_sample(0, 0, 1, 1);
    queue_sample(0, 0, 0, 1);
    queue_sample(0, 1, 0, 1);
    queue_sample(0, 1, 1, 1);
    queue_sample(0, 0, 1, 0);
    queue_sample(0, 0, 1, 1);
    queue_sample(0, 0, 0, 1);
    queue_sample(0, 1, 0, 1);
    queue_sample(0, 1, 1, 0);
    // Counter-clockwise detents, then a disabled button with an illegal jump.
    for (int i = 0; i < 2; i++) begin
      queue_sample(1, 1, 0, 0);
      queue_sample(1, 0, 0, 0);
      queue_sample(1, 0, 1, 0);
      queue_sample(1, 1, 1, 0);
    end
    queue_sample(7, 1, 1, 1);
    wait_idle();

    // Longer dead time, then a long press while the phases keep turning.
    set_regs(1'b1, 8'h01, 16'd6, 16'd12);
    spin_dir[0] = 1;
    for (int i = 0; i < 20; i++) spin_and_queue(0, i < 19);
    queue_sample(3, 1, 0, 1);
    wait_idle();

    set_regs(1'b1, 8'hff, 16'd0, 16'd0);
    run_random_phase(0, 0, 76);
    set_regs(1'b0, 8'ha5, 16'd1, 16'd3);
    run_random_phase(88, 0, 76);
    set_regs(1'b1, 8'h00, 16'd3, 16'd8);
    run_random_phase(0, 88, 76);
    set_regs(1'b0, 8'hff, 16'd0, 16'd2);
    run_random_phase(19, 19, 76);

    if (fail_cnt == 0 && expected_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/qeb_pkg.sv
hdl/qeb_if.sv
hdl/qeb_state_ram.sv
hdl/qeb_step.sv
hdl/qeb_event_queue.sv
hdl/quadrature_encoder_with_button_unit.sv
hdl/qeb_checker.sv
verif/tb_quadrature_encoder_with_button_unit.sv
